FILE: rtl/gbn_sw_pkg.sv
package gbn_sw_pkg;

	// Window geometry and chunk limit (both fit the field widths)
	localparam int unsigned WINDOW_MAX = 32;
	localparam int unsigned CHUNK_MAX  = 1000;
	localparam int unsigned SLOT_W     = 5;
	localparam int unsigned CNT_W      = 6;
	localparam int unsigned LEN_W      = 10;
	localparam int unsigned SEQ_W      = 32;

	localparam logic [CNT_W-1:0] LIMIT_RESET = 6'd8;

	typedef enum logic [1:0] {
		MODE_NEW     = 2'd0,
		MODE_ACK     = 2'd1,
		MODE_TIMEOUT = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_SEND  = 2'd0,
		KIND_FULL  = 2'd1,
		KIND_ACK   = 2'd2,
		KIND_EMPTY = 2'd3
	} kind_t;

	// controller -> datapath
	typedef struct packed {
		logic exec;         // handle the accepted transaction as a single result
		logic replay_start; // clear replay index
		logic rd;           // read payload length of current replay slot
		logic step;         // advance replay index
		logic replay_sel;   // outputs come from the replay path
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;        // nothing outstanding
		logic replay_last;  // current replay packet is the newest one
	} status_t;

endpackage

FILE: rtl/gbn_sw_ram.sv
module gbn_sw_ram #(
	parameter int unsigned WIDTH = 10,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/gbn_sw_ctrl.sv
module gbn_sw_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           mode,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  gbn_sw_pkg::status_t  status,
	output gbn_sw_pkg::cmd_t     cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_OUT  = 4'b0010,
		ST_RD   = 4'b0100,
		ST_RPL  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (gbn_sw_pkg::mode_t'(mode))
						gbn_sw_pkg::MODE_NEW,
						gbn_sw_pkg::MODE_ACK: begin
							cmd.exec = 1'b1;
							state_d  = ST_OUT;
						end
						gbn_sw_pkg::MODE_TIMEOUT: begin
							if (status.empty) begin
								cmd.exec = 1'b1;
								state_d  = ST_OUT;
							end else begin
								cmd.replay_start = 1'b1;
								state_d          = ST_RD;
							end
						end
						default: begin
							// unused code: dropped without a result
						end
					endcase
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_RPL;
			end
			ST_RPL: begin
				out_valid      = 1'b1;
				cmd.replay_sel = 1'b1;
				if (out_ready) begin
					if (status.replay_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.step = 1'b1;
						state_d  = ST_RD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_ready_excl_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result is pending");
`endif

endmodule

FILE: rtl/gbn_sw_dpath.sv
module gbn_sw_dpath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [1:0]                             mode,
	input  logic [gbn_sw_pkg::LEN_W-1:0]           chunk_length,
	input  logic [gbn_sw_pkg::SEQ_W-1:0]           ack_number,
	input  logic                                   ack_checksum_ok,
	input  logic                                   cfg_write_en,
	input  logic [gbn_sw_pkg::CNT_W-1:0]           cfg_write_data,
	input  gbn_sw_pkg::cmd_t                       cmd,
	output gbn_sw_pkg::status_t                    status,
	output logic [1:0]                             kind,
	output logic [gbn_sw_pkg::SEQ_W-1:0]           send_seq,
	output logic [gbn_sw_pkg::SLOT_W-1:0]          send_slot,
	output logic [gbn_sw_pkg::LEN_W-1:0]           send_length,
	output logic [gbn_sw_pkg::CNT_W-1:0]           in_flight
);

	localparam int unsigned SEQ_W  = gbn_sw_pkg::SEQ_W;
	localparam int unsigned SLOT_W = gbn_sw_pkg::SLOT_W;
	localparam int unsigned CNT_W  = gbn_sw_pkg::CNT_W;
	localparam int unsigned LEN_W  = gbn_sw_pkg::LEN_W;

	localparam logic [CNT_W-1:0] WIN_MAX  = CNT_W'(gbn_sw_pkg::WINDOW_MAX);
	localparam logic [LEN_W-1:0] CHK_MAX  = LEN_W'(gbn_sw_pkg::CHUNK_MAX);

	logic [CNT_W-1:0]  limit_q;
	logic [SEQ_W-1:0]  base_q;
	logic [SLOT_W-1:0] head_q;
	logic [CNT_W-1:0]  outst_q;
	logic [SLOT_W-1:0] idx_q;

	gbn_sw_pkg::kind_t res_kind_q;
	logic [SEQ_W-1:0]  res_seq_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic [LEN_W-1:0]  res_len_q;

	logic [CNT_W-1:0]  eff_limit;
	logic              full;
	logic [LEN_W-1:0]  clen_sat;
	logic [SLOT_W-1:0] wr_slot;
	logic [SLOT_W-1:0] rd_slot;
	logic [SEQ_W-1:0]  ack_dist;
	logic              ack_take;
	logic              new_take;
	logic [LEN_W-1:0]  rd_len;

	// limit raised to one and capped at the window size
	always_comb begin
		priority if (limit_q == '0) begin
			eff_limit = CNT_W'(1);
		end else if (limit_q > WIN_MAX) begin
			eff_limit = WIN_MAX;
		end else begin
			eff_limit = limit_q;
		end
	end

	assign full     = (outst_q >= eff_limit);
	assign clen_sat = (chunk_length > CHK_MAX) ? CHK_MAX : chunk_length;
	assign wr_slot  = head_q + outst_q[SLOT_W-1:0];
	assign rd_slot  = head_q + idx_q;
	assign ack_dist = ack_number - base_q;
	assign ack_take = ack_checksum_ok && (ack_dist <= {{(SEQ_W-CNT_W){1'b0}}, outst_q});
	assign new_take = cmd.exec && (gbn_sw_pkg::mode_t'(mode) == gbn_sw_pkg::MODE_NEW) && !full;

	gbn_sw_ram #(
		.WIDTH (LEN_W),
		.DEPTH (gbn_sw_pkg::WINDOW_MAX)
	) u_len_ram (
		.clk   (clk),
		.we    (new_take),
		.waddr (wr_slot),
		.wdata (clen_sat),
		.re    (cmd.rd),
		.raddr (rd_slot),
		.rdata (rd_len)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= gbn_sw_pkg::LIMIT_RESET;
			base_q  <= '0;
			head_q  <= '0;
			outst_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cfg_write_en) begin
				limit_q <= cfg_write_data;
			end
			if (cmd.exec) begin
				unique case (gbn_sw_pkg::mode_t'(mode))
					gbn_sw_pkg::MODE_NEW: begin
						if (!full) begin
							outst_q <= outst_q + CNT_W'(1);
						end
					end
					gbn_sw_pkg::MODE_ACK: begin
						if (ack_take) begin
							base_q  <= ack_number;
							head_q  <= head_q + ack_dist[SLOT_W-1:0];
							outst_q <= outst_q - ack_dist[CNT_W-1:0];
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.replay_start) begin
				idx_q <= '0;
			end else if (cmd.step) begin
				idx_q <= idx_q + SLOT_W'(1);
			end
		end
	end

	// single-result payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_seq_q  <= '0;
			res_slot_q <= '0;
			res_len_q  <= '0;
			unique case (gbn_sw_pkg::mode_t'(mode))
				gbn_sw_pkg::MODE_NEW: begin
					if (full) begin
						res_kind_q <= gbn_sw_pkg::KIND_FULL;
					end else begin
						res_kind_q <= gbn_sw_pkg::KIND_SEND;
						res_seq_q  <= base_q + {{(SEQ_W-CNT_W){1'b0}}, outst_q};
						res_slot_q <= wr_slot;
						res_len_q  <= clen_sat;
					end
				end
				gbn_sw_pkg::MODE_ACK: begin
					res_kind_q <= gbn_sw_pkg::KIND_ACK;
				end
				default: begin
					res_kind_q <= gbn_sw_pkg::KIND_EMPTY;
				end
			endcase
		end
	end

	assign status.empty       = (outst_q == '0);
	assign status.replay_last = ({1'b0, idx_q} + CNT_W'(1)) == outst_q;

	assign kind        = cmd.replay_sel ? gbn_sw_pkg::KIND_SEND : res_kind_q;
	assign send_seq    = cmd.replay_sel ? base_q + {{(SEQ_W-SLOT_W){1'b0}}, idx_q} : res_seq_q;
	assign send_slot   = cmd.replay_sel ? rd_slot : res_slot_q;
	assign send_length = cmd.replay_sel ? rd_len : res_len_q;
	assign in_flight   = outst_q;

`ifndef SYNTHESIS
	a_outst_bound: assert property (@(posedge clk) disable iff (!arst_n)
		outst_q <= WIN_MAX)
		else $error("outstanding count beyond window size");
	a_replay_idx: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.replay_sel |-> ({1'b0, idx_q} < outst_q))
		else $error("replay index past newest packet");
	a_new_count: assert property (@(posedge clk) disable iff (!arst_n)
		new_take |=> (outst_q == $past(outst_q) + CNT_W'(1)))
		else $error("accepted chunk did not grow the window");
`endif

endmodule

FILE: rtl/go_back_n_sender_window_unit.sv
// Channel   Handshake                  Payload
// input     in_valid / in_ready        mode, chunk_length, ack_number, ack_checksum_ok
// output    out_valid / out_ready      kind, send_seq, send_slot, send_length,
//                                      in_flight, last
// config    cfg_write_en (no wait)     cfg_write_data (window_limit)
//
// New-chunk and ACK transactions: the input is taken, and the registered result is
// offered in the cycle after.
// Timeout replay: the input is taken, then for each outstanding packet the slot
// length RAM is read and the result offered; the RAM read port is registered.
// One transaction is in the block at a time; a stalled output holds the block.
// Reset (arst_n low) clears the window and sets the limit to 8; no clearing pass.
module go_back_n_sender_window_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input transactions
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            mode,
	input  logic [gbn_sw_pkg::LEN_W-1:0]          chunk_length,
	input  logic [gbn_sw_pkg::SEQ_W-1:0]          ack_number,
	input  logic                                  ack_checksum_ok,
	// result transactions
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [1:0]                            kind,
	output logic [gbn_sw_pkg::SEQ_W-1:0]          send_seq,
	output logic [gbn_sw_pkg::SLOT_W-1:0]         send_slot,
	output logic [gbn_sw_pkg::LEN_W-1:0]          send_length,
	output logic [gbn_sw_pkg::CNT_W-1:0]          in_flight,
	output logic                                  last,
	// window limit register
	input  logic                                  cfg_write_en,
	input  logic [gbn_sw_pkg::CNT_W-1:0]          cfg_write_data
);

	gbn_sw_pkg::cmd_t    cmd;
	gbn_sw_pkg::status_t status;

	// sequencer: accept, single result, or replay walk over the window
	gbn_sw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// window state, slot length store and result registers
	gbn_sw_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.mode            (mode),
		.chunk_length    (chunk_length),
		.ack_number      (ack_number),
		.ack_checksum_ok (ack_checksum_ok),
		.cfg_write_en    (cfg_write_en),
		.cfg_write_data  (cfg_write_data),
		.cmd             (cmd),
		.status          (status),
		.kind            (kind),
		.send_seq        (send_seq),
		.send_slot       (send_slot),
		.send_length     (send_length),
		.in_flight       (in_flight)
	);

	// single results are always final; in a replay only the newest packet is
	assign last = cmd.replay_sel ? status.replay_last : 1'b1;

endmodule
